// ===== sv/skp_pkg.sv =====
package skp_pkg;

   localparam int MAX_ORDER = 256;
   localparam int PTR_AW    = $clog2(MAX_ORDER + 1);
   localparam int IDX_W     = 9;
   localparam int ADDR_W    = 16;
   localparam int VAL_W     = 64;
   localparam int CMD_W     = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PACK   = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic             outside;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } lookup_req_type;

endpackage

// ===== sv/skp_ptr_ram.sv =====
module skp_ptr_ram
   import skp_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PTR_AW-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_data,
   input  logic [PTR_AW-1:0] rd_addr_a,
   input  logic [PTR_AW-1:0] rd_addr_b,
   output logic [ADDR_W-1:0] rd_data_a,
   output logic [ADDR_W-1:0] rd_data_b
);

   logic [ADDR_W-1:0] mem [0:MAX_ORDER];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== sv/skp_lookup.sv =====
module skp_lookup
   import skp_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  lookup_req_type    req,
   input  logic [ADDR_W-1:0] ptr_hi,
   input  logic [ADDR_W-1:0] ptr_lo,
   output logic [ADDR_W-1:0] address
);

   lookup_req_type    ctx_ff;
   lookup_req_type    ctx_in;
   logic [ADDR_W-1:0] height;
   logic [ADDR_W-1:0] hi_ext;
   logic [ADDR_W-1:0] lo_ext;

   assign ctx_in = load ? req : ctx_ff;

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_in;
   end

   always_comb begin
      hi_ext = ADDR_W'(ctx_ff.hi);
      lo_ext = ADDR_W'(ctx_ff.lo);
      if (ctx_ff.hi == IDX_W'(1)) begin
         height = ADDR_W'(1);
      end else begin
         height = ptr_hi - ptr_lo;
      end
      if (ctx_ff.outside || (height > hi_ext) || (lo_ext <= (hi_ext - height))) begin
         address = '0;
      end else begin
         address = ptr_hi + lo_ext - hi_ext;
      end
   end

endmodule

// ===== sv/skyline_profile_pack_and_address.sv =====
// a pack request gives its result in the cycle after acceptance; a lookup request
// passes the end pointer memory read and context registers, then the result register
// throughput: one pack request per cycle; a lookup holds busy while in its lookup state
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
// reset clears the count, flags and control; end pointer memory is not cleared
module skyline_profile_pack_and_address
   import skp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_address,
   output logic [VAL_W-1:0]  rsp_value_out,
   output logic              rsp_from_lookup,
   output logic              rsp_zero_diagonal
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic              started_ff, started_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_address_ff, rsp_address_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_lookup_ff, rsp_lookup_in;
   logic              rsp_zd_ff, rsp_zd_in;

   logic              accept;
   logic              lookup_load;
   cmd_type           cmd;
   logic              pack_ok;
   logic              diag;
   logic              nonzero;
   logic              begin_store;
   logic [ADDR_W-1:0] count_inc;
   logic              wr_en;
   lookup_req_type    lk_req;
   logic [ADDR_W-1:0] ptr_hi;
   logic [ADDR_W-1:0] ptr_lo;
   logic [ADDR_W-1:0] lk_address;

   assign cmd       = cmd_type'(req_command);
   assign accept    = start && !busy;
   assign diag      = (req_row == req_col);
   assign nonzero   = |req_value[VAL_W-2:0];
   assign count_inc = count_ff + ADDR_W'(1);
   assign pack_ok   = (req_row != '0) && (req_col != '0) && (req_row <= req_col)
                      && (32'(req_col) <= MAX_ORDER);
   assign begin_store = started_ff || nonzero || diag;
   assign wr_en     = accept && (cmd == CMD_PACK) && pack_ok && diag;

   // order indices so that lo is not below the diagonal
   always_comb begin
      if (req_row > req_col) begin
         lk_req.lo = req_col;
         lk_req.hi = req_row;
      end else begin
         lk_req.lo = req_row;
         lk_req.hi = req_col;
      end
      lk_req.outside = (lk_req.lo == '0) || (32'(lk_req.hi) > MAX_ORDER);
   end

   skp_ptr_ram u_ptr_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (PTR_AW'(req_col)),
      .wr_data   (count_inc),
      .rd_addr_a (PTR_AW'(lk_req.hi)),
      .rd_addr_b (PTR_AW'(lk_req.hi - IDX_W'(1))),
      .rd_data_a (ptr_hi),
      .rd_data_b (ptr_lo)
   );

   skp_lookup u_lookup (
      .clock   (clock),
      .load    (lookup_load),
      .req     (lk_req),
      .ptr_hi  (ptr_hi),
      .ptr_lo  (ptr_lo),
      .address (lk_address)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == CMD_LOOKUP)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy        = 1'b0;
      lookup_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            lookup_load = start && (cmd == CMD_LOOKUP);
         end
         ST_LOOKUP: begin
            busy = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      count_in       = count_ff;
      started_in     = started_ff;
      err_in         = err_ff;
      rsp_valid_in   = 1'b0;
      rsp_address_in = rsp_address_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_lookup_in  = rsp_lookup_ff;
      rsp_zd_in      = rsp_zd_ff;
      if (state_ff == ST_LOOKUP) begin
         rsp_valid_in   = 1'b1;
         rsp_address_in = lk_address;
         rsp_value_in   = '0;
         rsp_lookup_in  = 1'b1;
         rsp_zd_in      = err_ff;
      end else if (accept) begin
         case (cmd)
            CMD_CLEAR: begin
               count_in   = '0;
               started_in = 1'b0;
               err_in     = 1'b0;
            end
            CMD_PACK: begin
               if (pack_ok && begin_store) begin
                  count_in       = count_inc;
                  started_in     = !diag;
                  err_in         = err_ff || (diag && !nonzero);
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = count_inc;
                  rsp_value_in   = req_value;
                  rsp_lookup_in  = 1'b0;
                  rsp_zd_in      = err_ff || (diag && !nonzero);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_address_ff <= rsp_address_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_lookup_ff  <= rsp_lookup_in;
      rsp_zd_ff      <= rsp_zd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address       = rsp_address_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_from_lookup   = rsp_lookup_ff;
   assign rsp_zero_diagonal = rsp_zd_ff;

   a_lookup_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_IDLE)
      else $error("lookup state held longer than one cycle");

   a_lookup_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> rsp_valid && rsp_from_lookup)
      else $error("lookup gave no result");

   a_pack_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_lookup |-> rsp_address == count_ff)
      else $error("packed address differs from count");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_lookup |-> rsp_zero_diagonal == err_ff)
      else $error("zero diagonal flag out of step");

endmodule

// ===== tb/skyline_profile_pack_and_address_checker.sv =====
module skyline_profile_pack_and_address_checker
   import skp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic [VAL_W-1:0]  req_value,
   input  logic              rsp_valid,
   input  logic [ADDR_W-1:0] rsp_address,
   input  logic [VAL_W-1:0]  rsp_value_out,
   input  logic              rsp_from_lookup,
   input  logic              rsp_zero_diagonal,
   output int                mismatch_count,
   output int                pending_count,
   output int                packs_checked,
   output int                lookups_checked
);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [VAL_W-1:0]  value_out;
      logic              from_lookup;
      logic              zero_diagonal;
   } skyline_result_type;

   localparam logic [VAL_W-1:0] MAGNITUDE_MASK = {1'b0, {(VAL_W - 1){1'b1}}};

   logic [ADDR_W-1:0] end_pointer [0:MAX_ORDER];
   logic [ADDR_W-1:0] entry_count;
   logic              column_open;
   logic              zero_diag_seen;

   skyline_result_type profile_results_q [$];

   int fail_tally    = 0;
   int pending_tally = 0;
   int packs_tally   = 0;
   int lookups_tally = 0;

   assign mismatch_count  = fail_tally;
   assign pending_count   = pending_tally;
   assign packs_checked   = packs_tally;
   assign lookups_checked = lookups_tally;

   // packed address of (r, c) folded into the upper triangle, 0 outside the profile
   function automatic logic [ADDR_W-1:0] profile_address(logic [IDX_W-1:0] r,
                                                         logic [IDX_W-1:0] c);
      logic [IDX_W-1:0]  lo;
      logic [IDX_W-1:0]  hi;
      logic [ADDR_W-1:0] height;
      lo = (r < c) ? r : c;
      hi = (r < c) ? c : r;
      if (lo == '0 || hi > MAX_ORDER) return '0;
      if (hi == 1) height = 1;
      else height = end_pointer[hi] - end_pointer[hi - 1];
      if (height > hi) return '0;
      if (lo <= hi - height) return '0;
      return end_pointer[hi] + lo - hi;
   endfunction

   task automatic predict_request();
      skyline_result_type res;
      logic               nonzero;
      nonzero = (req_value & MAGNITUDE_MASK) != '0;
      case (req_command)
         CMD_CLEAR: begin
            entry_count    = '0;
            column_open    = 1'b0;
            zero_diag_seen = 1'b0;
         end
         CMD_LOOKUP: begin
            res.address       = profile_address(req_row, req_col);
            res.value_out     = '0;
            res.from_lookup   = 1'b1;
            res.zero_diagonal = zero_diag_seen;
            profile_results_q.push_back(res);
         end
         CMD_PACK: begin
            if (req_row != '0 && req_col != '0 && req_row <= req_col
                && req_col <= MAX_ORDER) begin
               if (nonzero || req_row == req_col) column_open = 1'b1;
               if (column_open) begin
                  entry_count = entry_count + 1'b1;
                  if (req_row == req_col) begin
                     end_pointer[req_col] = entry_count;
                     column_open = 1'b0;
                     if (!nonzero) zero_diag_seen = 1'b1;
                  end
                  res.address       = entry_count;
                  res.value_out     = req_value;
                  res.from_lookup   = 1'b0;
                  res.zero_diagonal = zero_diag_seen;
                  profile_results_q.push_back(res);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
         fail_tally++;
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      skyline_result_type due;
      if (reset) begin
         for (int i = 0; i <= MAX_ORDER; i++) end_pointer[i] = '0;
         entry_count    = '0;
         column_open    = 1'b0;
         zero_diag_seen = 1'b0;
         profile_results_q.delete();
      end else begin
         if (rsp_valid) begin
            if (profile_results_q.size() == 0) begin
               fail_tally++;
               $error("unexpected result: rsp_address %0h rsp_from_lookup %0b",
                      rsp_address, rsp_from_lookup);
            end else begin
               due = profile_results_q.pop_front();
               compare_field("rsp_address", due.address, rsp_address);
               compare_field("rsp_value_out", due.value_out, rsp_value_out);
               compare_field("rsp_from_lookup", due.from_lookup, rsp_from_lookup);
               compare_field("rsp_zero_diagonal", due.zero_diagonal, rsp_zero_diagonal);
               if (due.from_lookup) lookups_tally++;
               else packs_tally++;
            end
         end
         if (start && !busy) predict_request();
      end
      pending_tally = profile_results_q.size();
   end

endmodule

// ===== tb/skyline_profile_pack_and_address_test.sv =====
module skyline_profile_pack_and_address_test;
   import skp_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_TARGET = 400;
   localparam int QUIET_STRETCH = 150;
   localparam int DRAIN_LIMIT   = 64;
   localparam int INDEX_TOP     = (1 << IDX_W) - 1;

   localparam logic [CMD_W-1:0] CMD_SPARE     = 2'd3;
   localparam logic [VAL_W-1:0] ONE_ENTRY     = 64'h3FF0_0000_0000_0000;
   localparam logic [VAL_W-1:0] SIGN_ONLY     = 64'h8000_0000_0000_0000;
   localparam logic [VAL_W-1:0] MAX_MAGNITUDE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic [CMD_W-1:0]  req_command = '0;
   logic [IDX_W-1:0]  req_row     = '0;
   logic [IDX_W-1:0]  req_col     = '0;
   logic [VAL_W-1:0]  req_value   = '0;
   logic              busy;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_address;
   logic [VAL_W-1:0]  rsp_value_out;
   logic              rsp_from_lookup;
   logic              rsp_zero_diagonal;

   int fail_total;
   int pending_total;
   int packs_seen;
   int lookups_seen;

   int requests_sent = 0;
   int useful_sent   = 0;
   int cycle_count   = 0;
   bit quiet_sender  = 1'b0;
   bit col_written [0:MAX_ORDER];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   skyline_profile_pack_and_address i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_address       (rsp_address),
      .rsp_value_out     (rsp_value_out),
      .rsp_from_lookup   (rsp_from_lookup),
      .rsp_zero_diagonal (rsp_zero_diagonal)
   );

   skyline_profile_pack_and_address_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_address       (rsp_address),
      .rsp_value_out     (rsp_value_out),
      .rsp_from_lookup   (rsp_from_lookup),
      .rsp_zero_diagonal (rsp_zero_diagonal),
      .mismatch_count    (fail_total),
      .pending_count     (pending_total),
      .packs_checked     (packs_seen),
      .lookups_checked   (lookups_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [VAL_W-1:0] zero_entry();
      return ($urandom_range(1) == 0) ? '0 : SIGN_ONLY;
   endfunction

   function automatic logic [VAL_W-1:0] nonzero_entry();
      logic [VAL_W-1:0] v;
      v = {$urandom, $urandom};
      if (v[VAL_W-2:0] == '0) v[0] = 1'b1;
      return v;
   endfunction

   function automatic logic [VAL_W-1:0] random_entry();
      case ($urandom_range(9))
         0: return zero_entry();
         1: return ($urandom_range(1) == 0) ? ALL_ONES : MAX_MAGNITUDE;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // a lookup may only touch end pointers that have been written since reset
   function automatic bit lookup_is_safe(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
      int lo;
      int hi;
      lo = (r < c) ? r : c;
      hi = (r < c) ? c : r;
      if (lo == 0 || hi > MAX_ORDER) return 1'b1;
      return col_written[hi] && col_written[hi - 1];
   endfunction

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
                               logic [IDX_W-1:0] c, logic [VAL_W-1:0] v);
      start       <= 1'b1;
      req_command <= cmd;
      req_row     <= r;
      req_col     <= c;
      req_value   <= v;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (cmd == CMD_PACK && r == c && c != '0 && c <= MAX_ORDER) col_written[c] = 1'b1;
      if (!(cmd == CMD_SPARE
            || (cmd == CMD_PACK && (r == '0 || c == '0 || r > c || c > MAX_ORDER))))
         useful_sent++;
      if (!quiet_sender && $urandom_range(99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic send_random_lookup(int col_first, int col_last);
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      int               reach;
      c = $urandom_range(col_last, col_first);
      reach = (c > 8) ? 8 : c - 1;
      if ($urandom_range(4) < 3) r = c - $urandom_range(reach, 0);
      else r = $urandom_range(c, 1);
      if ($urandom_range(1) == 0) {r, c} = {c, r};
      if ($urandom_range(9) == 0) begin
         r = $urandom;
         c = $urandom;
      end
      if (!lookup_is_safe(r, c)) r = '0;
      send_request(CMD_LOOKUP, r, c, {$urandom, $urandom});
   endtask

   task automatic send_noise();
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      logic [CMD_W-1:0] cmd;
      r = $urandom;
      c = $urandom;
      cmd = $urandom;
      case ($urandom_range(3))
         0: send_request(CMD_SPARE, r, c, {$urandom, $urandom});
         1: begin
            c = $urandom_range(MAX_ORDER - 1, 1);
            r = $urandom_range(INDEX_TOP, c + 1);
            send_request(CMD_PACK, r, c, nonzero_entry());
         end
         2: begin
            if ($urandom_range(1) == 0) r = '0;
            else if ($urandom_range(1) == 0) c = '0;
            else c = $urandom_range(INDEX_TOP, MAX_ORDER + 1);
            send_request(CMD_PACK, r, c, nonzero_entry());
         end
         default: begin
            if (cmd == CMD_LOOKUP && !lookup_is_safe(r, c)) r = '0;
            send_request(cmd, r, c, {$urandom, $urandom});
         end
      endcase
   endtask

   // one matrix in column order, each column with a short run of leading zeros
   task automatic pack_random_matrix();
      int               span;
      int               first_col;
      int               last_col;
      int               reach;
      int               top_row;
      int               lead_row;
      logic [VAL_W-1:0] v;
      span = ($urandom_range(7) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
      first_col = ($urandom_range(2) == 0) ? $urandom_range(MAX_ORDER - span + 1, 2) : 1;
      last_col = first_col + span - 1;
      if ($urandom_range(3) != 0) send_request(CMD_CLEAR, $urandom, $urandom, random_entry());
      for (int c = first_col; c <= last_col; c++) begin
         reach = (c <= 12) ? c - 1 : (($urandom_range(15) == 0) ? 20 : 6);
         if (reach > c - 1) reach = c - 1;
         top_row = c - int'($urandom_range(reach, 0));
         lead_row = top_row - int'($urandom_range(2, 0));
         if (lead_row < 1) lead_row = 1;
         for (int r = lead_row; r <= c; r++) begin
            if (r < top_row) v = zero_entry();
            else if (r == c) v = ($urandom_range(15) == 0) ? zero_entry() : nonzero_entry();
            else if (r == top_row) v = nonzero_entry();
            else v = random_entry();
            send_request(CMD_PACK, r, c, v);
            if ($urandom_range(24) == 0) send_noise();
         end
         if ($urandom_range(1) == 0) send_random_lookup(first_col, c);
      end
   endtask

   task automatic run_random(int goal);
      while (useful_sent < goal) begin
         if ($urandom_range(99) < 12) send_noise();
         else pack_random_matrix();
      end
   endtask

   task automatic run_directed();
      send_request(CMD_CLEAR, '0, '0, '0);
      send_request(CMD_PACK, 1, 1, ONE_ENTRY);
      // negative zero lies outside the profile
      send_request(CMD_PACK, 1, 2, SIGN_ONLY);
      send_request(CMD_PACK, 2, 2, ALL_ONES);
      send_request(CMD_PACK, 1, 3, SIGN_ONLY | 64'd1);
      send_request(CMD_PACK, 2, 3, '0);
      // zero diagonal raises the sticky flag
      send_request(CMD_PACK, 3, 3, SIGN_ONLY);
      send_request(CMD_PACK, 4, 3, ONE_ENTRY);
      send_request(CMD_PACK, 0, 3, ONE_ENTRY);
      send_request(CMD_PACK, 5, 0, ONE_ENTRY);
      send_request(CMD_PACK, 1, MAX_ORDER + 1, ONE_ENTRY);
      send_request(CMD_PACK, INDEX_TOP, INDEX_TOP, ALL_ONES);
      send_request(CMD_SPARE, INDEX_TOP, INDEX_TOP, ALL_ONES);
      send_request(CMD_LOOKUP, 1, 1, '0);
      send_request(CMD_LOOKUP, 3, 1, ALL_ONES);
      send_request(CMD_LOOKUP, 1, 2, '0);
      send_request(CMD_LOOKUP, 0, 3, '0);
      send_request(CMD_LOOKUP, 2, INDEX_TOP, '0);
      send_request(CMD_LOOKUP, 0, 0, '0);
      send_request(CMD_CLEAR, INDEX_TOP, INDEX_TOP, ALL_ONES);
      send_request(CMD_PACK, 2, 2, ONE_ENTRY);
      // stale pointers from the previous matrix give an inconsistent height
      send_request(CMD_LOOKUP, 3, 3, '0);
      send_request(CMD_LOOKUP, 2, 2, '0);
      send_request(CMD_PACK, MAX_ORDER, MAX_ORDER, MAX_MAGNITUDE);
   endtask

   initial begin : stimulus
      int drain;
      for (int i = 0; i <= MAX_ORDER; i++) col_written[i] = (i == 0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(useful_sent + RANDOM_TARGET);
      quiet_sender = 1'b1;
      run_random(useful_sent + QUIET_STRETCH);
      quiet_sender = 1'b0;
      run_random(useful_sent + RANDOM_TARGET - QUIET_STRETCH);
      start <= 1'b0;
      drain = 0;
      while (pending_total != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      $display("Sent %0d requests (%0d with effect), checked %0d packed entries and %0d lookups",
               requests_sent, useful_sent, packs_seen, lookups_seen);
      $display("Stimulus included outside-profile entries, zero diagonals and stale pointers");
      if (fail_total == 0 && pending_total == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
